// ===== hw/rtl/cic_decimator_with_compensation_unit_macros.svh =====
// Assertion macros shared by the CIC decimator RTL.
`ifndef CIC_DECIMATOR_WITH_COMPENSATION_UNIT_MACROS_SVH
`define CIC_DECIMATOR_WITH_COMPENSATION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define CICD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cicd assertion failed");
// Next-cycle implication, checked outside reset.
`define CICD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cicd assertion failed");
`else
`define CICD_ASSERT_SAME(label, clk, rst, ante, cons)
`define CICD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cicd_pkg.sv =====
// Package with types and constants of the CIC decimator.
`timescale 1ns / 1ps
package cicd_pkg;
   localparam int SAMPLE_W       = 16;
   localparam int ACC_WIDTH_DEF  = 36;
   localparam int NUM_STAGES     = 4;
   localparam int FACTOR_W       = 10;
   localparam int GAIN_W         = 6;
   localparam int CSR_DATA_W     = 10;
   localparam int CSR_INDEX_W    = 1;
   localparam int FIFO_DEPTH     = 16;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int OCC_W          = $clog2(FIFO_DEPTH + 1);
   localparam int RESULT_LSB     = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DECIMATION = 1'b0,
      CSR_GAIN       = 1'b1
   } csr_index_type;

   // Marks a pipeline slot: valid for any sample, fire when it yields a result.
   typedef struct packed {
      logic valid;
      logic fire;
   } tag_type;
endpackage

// ===== hw/rtl/cicd_req_if.sv =====
// Input sample channel interface.
`timescale 1ns / 1ps
interface cicd_req_if
   import cicd_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// ===== hw/rtl/cicd_rsp_if.sv =====
// Result sample channel interface.
`timescale 1ns / 1ps
interface cicd_rsp_if
   import cicd_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/cicd_int_cell.sv =====
// One integrator cell of the CIC chain.
`timescale 1ns / 1ps
module cicd_int_cell
   import cicd_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tag_type              tag_in,
   input  logic [ACC_WIDTH-1:0] data_in,
   output tag_type              tag_out,
   output logic [ACC_WIDTH-1:0] data_out
);
   tag_type              tag_ff;
   logic [ACC_WIDTH-1:0] acc_ff;
   logic [ACC_WIDTH-1:0] acc_in;

   assign acc_in = tag_in.valid ? acc_ff + data_in : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
         acc_ff <= '0;
      end else begin
         tag_ff <= tag_in;
         acc_ff <= acc_in;
      end
   end

   assign tag_out  = tag_ff;
   assign data_out = acc_ff;
endmodule

// ===== hw/rtl/cicd_comb_cell.sv =====
// One comb (difference) cell of the CIC chain.
`timescale 1ns / 1ps
module cicd_comb_cell
   import cicd_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tag_type              tag_in,
   input  logic [ACC_WIDTH-1:0] data_in,
   output tag_type              tag_out,
   output logic [ACC_WIDTH-1:0] data_out
);
   tag_type              tag_ff;
   logic [ACC_WIDTH-1:0] delay_ff;
   logic [ACC_WIDTH-1:0] diff_ff;
   logic                 take;

   // Only samples at the decimated rate move the comb delay.
   assign take = tag_in.valid && tag_in.fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         delay_ff <= '0;
      end else begin
         tag_ff <= tag_in;
         if (take) begin
            delay_ff <= data_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         diff_ff <= data_in - delay_ff;
      end
   end

   assign tag_out  = tag_ff;
   assign data_out = diff_ff;
endmodule

// ===== hw/rtl/cicd_comp.sv =====
// Gain shift and three-tap compensation filter.
`timescale 1ns / 1ps
module cicd_comp
   import cicd_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [GAIN_W-1:0]          gain_shift,
   input  tag_type                    tag_in,
   input  logic [ACC_WIDTH-1:0]       data_in,
   output tag_type                    tag_out,
   output logic signed [SAMPLE_W-1:0] result
);
   tag_type                    tap_tag_ff;
   tag_type                    res_tag_ff;
   logic [ACC_WIDTH-1:0]       tap0_ff;
   logic [ACC_WIDTH-1:0]       tap1_ff;
   logic [ACC_WIDTH-1:0]       tap2_ff;
   logic [ACC_WIDTH-1:0]       shifted;
   logic [ACC_WIDTH-1:0]       comp;
   logic signed [SAMPLE_W-1:0] res_ff;

   // A shift of the full width or more leaves pure sign fill.
   assign shifted = ACC_WIDTH'($signed(data_in) >>> gain_shift);

   // n0 - 6*n1 + n2, with 6*n1 built from two shifts.
   assign comp = tap0_ff - (tap1_ff << 2) - (tap1_ff << 1) + tap2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_tag_ff <= '0;
         res_tag_ff <= '0;
         tap0_ff    <= '0;
         tap1_ff    <= '0;
         tap2_ff    <= '0;
      end else begin
         tap_tag_ff <= tag_in;
         res_tag_ff <= tap_tag_ff;
         if (tag_in.valid && tag_in.fire) begin
            tap0_ff <= shifted;
            tap1_ff <= tap0_ff;
            tap2_ff <= tap1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= comp[RESULT_LSB +: SAMPLE_W];
   end

   assign tag_out = res_tag_ff;
   assign result  = res_ff;
endmodule

// ===== hw/rtl/cicd_fifo.sv =====
// Result queue that feeds the response channel.
`timescale 1ns / 1ps
module cicd_fifo
   import cicd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic signed [SAMPLE_W-1:0] push_data,
   output logic                       pop,
   output logic [OCC_W-1:0]           count,
   cicd_rsp_if.source                 rsp_if
);
   logic signed [SAMPLE_W-1:0] mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]      wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]      rd_ptr_ff;
   logic [OCC_W-1:0]           count_ff;
   logic [OCC_W-1:0]           count_in;

   assign rsp_if.valid      = (count_ff != '0);
   assign rsp_if.sample_out = mem_ff[rd_ptr_ff];
   assign pop               = rsp_if.valid && rsp_if.ready;
   assign count_in          = count_ff + OCC_W'(push) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count = count_ff;
endmodule

// ===== hw/rtl/cic_decimator_with_compensation_unit.sv =====
// Top level of the four-stage CIC decimator with compensation filter.
//
// Samples enter on req_if (valid/ready); a transaction moves one signed
// 16-bit sample. Every decimation_factor-th sample yields one result on
// rsp_if; the other samples yield none. Configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while the block
// is idle, which the block itself does not enforce. A sample passes four
// integrator cells, four comb cells, a gain-shift stage and a compensation
// stage, and its result is queued in a 16-entry output queue. The unit
// accepts one sample per cycle while req_if.ready is high. req_if.ready
// falls only when the samples in the cell chain plus the queued results
// reach the queue depth, so a stalled receiver halts input after at most
// 16 outstanding samples and nothing is lost. Reset clears the integrator,
// comb delay and compensation tap state, the phase counter, the queue and
// sets decimation_factor to 1 and gain_shift to 0; no clearing pass is
// needed.
`timescale 1ns / 1ps
`include "cic_decimator_with_compensation_unit_macros.svh"
module cic_decimator_with_compensation_unit
   import cicd_pkg::*;
#(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   cicd_req_if.sink               req_if,
   cicd_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   logic [FACTOR_W-1:0]        factor_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic [FACTOR_W-1:0]        phase_ff;
   logic [FACTOR_W-1:0]        phase_next;
   logic [OCC_W-1:0]           occ_ff;
   logic [OCC_W-1:0]           occ_in;
   logic                       accept;
   logic                       fire;
   tag_type                    int_tag  [NUM_STAGES+1];
   logic [ACC_WIDTH-1:0]       int_data [NUM_STAGES+1];
   tag_type                    comb_tag  [NUM_STAGES+1];
   logic [ACC_WIDTH-1:0]       comb_data [NUM_STAGES+1];
   tag_type                    res_tag;
   logic signed [SAMPLE_W-1:0] res_data;
   logic                       push;
   logic                       drop;
   logic                       pop;
   logic [OCC_W-1:0]           fifo_count;

   assign req_if.ready = (occ_ff < OCC_W'(FIFO_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign phase_next   = phase_ff + 1'b1;
   assign fire         = (phase_next == factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_W'(1);
         gain_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DECIMATION: factor_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_GAIN:       gain_ff   <= csr_wdata[GAIN_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= fire ? '0 : phase_next;
      end
   end

   assign int_tag[0]  = '{valid: accept, fire: fire};
   assign int_data[0] = ACC_WIDTH'($signed(req_if.sample_in));

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_int
      cicd_int_cell #(.ACC_WIDTH(ACC_WIDTH)) u_int (
         .clock    (clock),
         .reset    (reset),
         .tag_in   (int_tag[i]),
         .data_in  (int_data[i]),
         .tag_out  (int_tag[i+1]),
         .data_out (int_data[i+1])
      );
   end

   assign comb_tag[0]  = int_tag[NUM_STAGES];
   assign comb_data[0] = int_data[NUM_STAGES];

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_comb
      cicd_comb_cell #(.ACC_WIDTH(ACC_WIDTH)) u_comb (
         .clock    (clock),
         .reset    (reset),
         .tag_in   (comb_tag[i]),
         .data_in  (comb_data[i]),
         .tag_out  (comb_tag[i+1]),
         .data_out (comb_data[i+1])
      );
   end

   cicd_comp #(.ACC_WIDTH(ACC_WIDTH)) u_comp (
      .clock      (clock),
      .reset      (reset),
      .gain_shift (gain_ff),
      .tag_in     (comb_tag[NUM_STAGES]),
      .data_in    (comb_data[NUM_STAGES]),
      .tag_out    (res_tag),
      .result     (res_data)
   );

   assign push = res_tag.valid && res_tag.fire;
   assign drop = res_tag.valid && !res_tag.fire;

   cicd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res_data),
      .pop       (pop),
      .count     (fifo_count),
      .rsp_if    (rsp_if)
   );

   // Occupancy counts samples in the cell chain plus results in the queue.
   assign occ_in = occ_ff + OCC_W'(accept) - OCC_W'(drop) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `CICD_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(FIFO_DEPTH))
   `CICD_ASSERT_SAME(a_queue_within_occ, clock, reset, 1'b1, fifo_count <= occ_ff)
   `CICD_ASSERT_NEXT(a_push_shows, clock, reset, push, rsp_if.valid)
endmodule

// ===== bench/tb_cic_decimator_with_compensation_unit.sv =====
// Self-checking testbench of the CIC decimator with compensation filter.
`timescale 1ns / 1ps

module tb_cic_decimator_with_compensation_unit;
   import cicd_pkg::*;

   localparam int ACC_W      = ACC_WIDTH_DEF;
   localparam int SETTLE_CYC = 24;
   localparam int HOLD_CYC   = 300;

   // Tracks the filter state and holds the decimated samples still owed.
   class cic_scoreboard;
      logic [FACTOR_W-1:0]        factor;
      logic [GAIN_W-1:0]          gain;
      logic [FACTOR_W-1:0]        phase;
      logic [ACC_W-1:0]           integ[NUM_STAGES];
      logic [ACC_W-1:0]           comb_dly[NUM_STAGES];
      logic [ACC_W-1:0]           taps[3];
      logic signed [SAMPLE_W-1:0] owed_samples[$];
      int                         errors;

      function new();
         factor = 1;
         gain   = 0;
         phase  = 0;
         errors = 0;
         for (int i = 0; i < NUM_STAGES; i++) begin
            integ[i]    = '0;
            comb_dly[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            taps[i] = '0;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_DECIMATION) begin
            factor = value[FACTOR_W-1:0];
         end else begin
            gain = value[GAIN_W-1:0];
         end
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         logic [ACC_W-1:0] x;
         logic [ACC_W-1:0] stage;
         logic [ACC_W-1:0] diff;
         logic [ACC_W-1:0] comp;
         x = {{(ACC_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
         integ[0] = integ[0] + x;
         for (int i = 1; i < NUM_STAGES; i++) begin
            integ[i] = integ[i] + integ[i-1];
         end
         phase = phase + 1'b1;
         if (phase != factor) return;
         phase = '0;
         stage = integ[NUM_STAGES-1];
         for (int i = 0; i < NUM_STAGES; i++) begin
            diff        = stage - comb_dly[i];
            comb_dly[i] = stage;
            stage       = diff;
         end
         taps[2] = taps[1];
         taps[1] = taps[0];
         // A shift at or beyond the accumulator width leaves only sign fill.
         if (gain >= ACC_W) begin
            taps[0] = {ACC_W{stage[ACC_W-1]}};
         end else begin
            taps[0] = $unsigned($signed(stage) >>> gain);
         end
         comp = taps[0] - 6 * taps[1] + taps[2];
         owed_samples.push_back(comp[RESULT_LSB +: SAMPLE_W]);
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (owed_samples.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = owed_samples.pop_front();
         if (want !== got) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction

      function int pending();
         return owed_samples.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int  hold_left = 0;

   cic_scoreboard sb;

   cicd_req_if req_chan ();
   cicd_rsp_if rsp_chan ();

   cic_decimator_with_compensation_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= HOLD_CYC;
         hold_taken <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Outputs change only at the rising edge, so the falling edge sees the
   // values that the next rising edge will act on.
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_result(rsp_chan.sample_out);
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return SAMPLE_W'($signed($urandom_range(15)) - 8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      logic taken;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sample_in <= s;
      forever begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
         if (taken) break;
      end
      sb.note_sample(s);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // Samples that yield nothing may still be in the cell chain.
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_settings(input int unsigned factor, input int unsigned gain);
      csr_we    <= 1'b1;
      csr_index <= CSR_DECIMATION;
      csr_wdata <= CSR_DATA_W'(factor);
      @(posedge clock);
      sb.set_register(CSR_DECIMATION, CSR_DATA_W'(factor));
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_W'(gain);
      @(posedge clock);
      sb.set_register(CSR_GAIN, CSR_DATA_W'(gain));
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned factor, input int unsigned gain,
                            input int count, input int snd_idle, input int rcv_idle,
                            input logic with_hold);
      wait_drained();
      write_settings(factor, gain);
      req_idle_pct = snd_idle;
      rsp_idle_pct = rcv_idle;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == 30) hold_request <= 1'b1;
         push_sample(rand_sample());
      end
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.sample_in = '0;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes at the reset settings, then sign fill.
      write_settings(1, 0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (4) push_sample(16'sh7FFF);
      repeat (4) push_sample(-16'sh8000);
      push_sample(16'sh0000);
      push_sample(-16'sh0001);
      push_sample(16'sh0001);
      push_sample(16'sh5555);
      push_sample(-16'sh5556);
      wait_drained();
      write_settings(1, 63);
      push_sample(-16'sh8000);
      push_sample(-16'sh0001);
      push_sample(16'sh7FFF);
      push_sample(16'sh0000);
      push_sample(-16'sh1234);

      // Random part under three idling patterns; each phase ends on a
      // whole number of decimation periods.
      run_phase(2, 3, 36, 15, 76, 1'b0);
      run_phase(4, 9, 36, 15, 76, 1'b0);
      run_phase(1, 35, 36, 76, 15, 1'b0);
      run_phase(7, 14, 28, 76, 15, 1'b0);
      run_phase(1, 0, 60, 0, 0, 1'b1);
      run_phase(3, 5, 30, 0, 0, 1'b0);

      // Leave the count at five, then set a zero factor below it; the
      // counter must wrap around and fire once on reaching zero again.
      run_phase(8, 12, 5, 0, 0, 1'b0);
      run_phase(0, 30, 1019, 0, 0, 1'b0);
      run_phase(5, 20, 10, 15, 15, 1'b0);

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("cic_decimator_with_compensation_unit verification clean");
      end else begin
         $display("cic_decimator_with_compensation_unit verification failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("cic_decimator_with_compensation_unit verification failed");
      $finish;
   end
endmodule
